### hw/rtl/coo_spmv_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the coo sparse matrix-vector multiply block
// no dependencies; used by the channel interfaces, the divider and the top level
package coo_spmv_pkg;

   // fixed field widths
   localparam int MODE_W    = 2;
   localparam int COL_IDX_W = 6;
   localparam int ROW_IDX_W = 6;
   localparam int VAL_W     = 32;
   localparam int CFG_W     = 7;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 3;

   // item modes
   typedef enum logic [MODE_W-1:0] {
      MODE_VECTOR  = 2'd0,
      MODE_MATRIX  = 2'd1,
      MODE_COMPUTE = 2'd2
   } mode_type;

   // register indexes, taken from paddr[ADDR_W-1]
   localparam logic [0:0] REG_ROW_COUNT = 1'b0;
   localparam logic [0:0] REG_COL_COUNT = 1'b1;

   localparam logic [CFG_W-1:0] ROW_COUNT_RESET = 7'd10;
   localparam logic [CFG_W-1:0] COL_COUNT_RESET = 7'd10;

   // divider status toward the top level
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### hw/rtl/coo_spmv_req_if.sv
`timescale 1ns / 1ps
// input word channel: mode, column index and value with valid/ready
// depends on coo_spmv_pkg
interface coo_spmv_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [coo_spmv_pkg::MODE_W-1:0]       mode;
   logic [coo_spmv_pkg::COL_IDX_W-1:0]    col_index;
   logic signed [coo_spmv_pkg::VAL_W-1:0] value;

   modport source (output valid, mode, col_index, value, input ready);
   modport sink   (input valid, mode, col_index, value, output ready);
endinterface

### hw/rtl/coo_spmv_rsp_if.sv
`timescale 1ns / 1ps
// result word channel: row index, row sum and last-row flag with valid/ready
// depends on coo_spmv_pkg
interface coo_spmv_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [coo_spmv_pkg::ROW_IDX_W-1:0]    row_index;
   logic signed [coo_spmv_pkg::VAL_W-1:0] row_sum;
   logic                                  last_row;

   modport source (output valid, row_index, row_sum, last_row, input ready);
   modport sink   (input valid, row_index, row_sum, last_row, output ready);
endinterface

### hw/rtl/coo_spmv_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
// depends on coo_spmv_pkg for the status struct
module coo_spmv_div #(
   parameter int NUM_W = 13,
   parameter int DEN_W = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [NUM_W-1:0]             num,
   input  logic [DEN_W-1:0]             den,
   output coo_spmv_pkg::div_status_type status,
   output logic [NUM_W-1:0]             quo,
   output logic [DEN_W-1:0]             rem
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    rem_sh;
   logic [DEN_W+1:0]  diff;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
      diff    = (DEN_W+2)'(rem_sh) - (DEN_W+2)'(den_ff);
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         step_in = STEP_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[NUM_W-2:0], ~diff[DEN_W+1]};
         rem_in  = diff[DEN_W+1] ? rem_sh[DEN_W-1:0] : diff[DEN_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quo         = quo_ff;
   assign rem         = rem_ff;

endmodule

### hw/rtl/coo_sparse_matrix_vector_multiply_top.sv
`timescale 1ns / 1ps
// coo sparse matrix-vector multiply: vector store, coordinate entry table, row sums
// depends on coo_spmv_pkg, coo_spmv_req_if, coo_spmv_rsp_if and coo_spmv_div
//
//   channel   dir  handshake              word
//   req_chan  in   valid/ready            mode, col_index, value
//   rsp_chan  out  valid/ready            row_index, row_sum, last_row
//   apb       in   psel/penable/pwrite    paddr, pwdata -> prdata (pready tied high)
//
// vector and matrix words may come back to back
// a compute word walks the stored entries at one per cycle through a four stage
//   read / multiply / accumulate pipeline, then emits one result word per configured
//   row through the read, load and show states, waiting on rsp_chan.ready
// a col_count write recomputes the load row and column from the load position
//   in the serial divider, during which req_chan is held off
// reset is synchronous; the vector store and entry table need no clearing,
//   row sums start each compute from per-row valid bits
module coo_sparse_matrix_vector_multiply_top #(
   parameter int MAX_DIM     = 64,
   parameter int MAX_ENTRIES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   coo_spmv_req_if.sink                      req_chan,
   coo_spmv_rsp_if.source                    rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [coo_spmv_pkg::ADDR_W-1:0]   paddr,
   input  logic [coo_spmv_pkg::DATA_W-1:0]   pwdata,
   output logic [coo_spmv_pkg::DATA_W-1:0]   prdata,
   output logic                              pready
);

   localparam int CFG_W    = coo_spmv_pkg::CFG_W;
   localparam int VAL_W    = coo_spmv_pkg::VAL_W;
   localparam int DIM_IW   = $clog2(MAX_DIM);          // row / column index
   localparam int DIM_CW   = $clog2(MAX_DIM + 1);      // row / column count
   localparam int CMP_W    = (DIM_CW > CFG_W) ? DIM_CW : CFG_W;
   localparam int CI_W     = coo_spmv_pkg::COL_IDX_W;
   localparam int CI_CMP_W = (DIM_CW > CI_W) ? DIM_CW : CI_W;
   localparam int POS_W    = $clog2(MAX_DIM * MAX_DIM + 1);
   localparam int ENT_AW   = $clog2(MAX_ENTRIES);
   localparam int ENT_CW   = $clog2(MAX_ENTRIES + 1);
   localparam int ENT_W    = 2 * DIM_IW + VAL_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_READ,
      ST_LOAD,
      ST_SHOW
   } state_type;

   // zero acts as one, anything above the maximum as the maximum
   function automatic logic [DIM_CW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [CMP_W-1:0] w;
      w = CMP_W'(v);
      if (w == '0) begin
         return DIM_CW'(1);
      end else if (w > CMP_W'(MAX_DIM)) begin
         return DIM_CW'(MAX_DIM);
      end
      return DIM_CW'(w);
   endfunction

   // ---------------------------------------------------------------- registers
   state_type                 state_ff, state_in;
   logic [CFG_W-1:0]          row_cnt_ff, row_cnt_in;
   logic [CFG_W-1:0]          col_cnt_ff, col_cnt_in;
   logic                      div_pend_ff, div_pend_in;
   logic [ENT_CW-1:0]         ent_cnt_ff, ent_cnt_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [POS_W-1:0]          load_row_ff, load_row_in;
   logic [DIM_IW-1:0]         load_col_ff, load_col_in;
   logic [ENT_CW-1:0]         walk_idx_ff, walk_idx_in;
   logic                      p1_vld_ff, p1_vld_in;
   logic                      p2_vld_ff, p2_vld_in;
   logic                      p3_vld_ff, p3_vld_in;
   logic                      wr_vld_ff, wr_vld_in;
   logic [MAX_DIM-1:0]        row_vld_ff, row_vld_in;
   logic [DIM_IW-1:0]         emit_row_ff, emit_row_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   logic [coo_spmv_pkg::ROW_IDX_W-1:0] rsp_row_ff, rsp_row_in;
   logic [VAL_W-1:0]          rsp_sum_ff, rsp_sum_in;
   logic                      rsp_last_ff, rsp_last_in;

   // pipeline payload
   logic [DIM_IW-1:0]         p2_row_ff;
   logic [VAL_W-1:0]          p2_val_ff;
   logic [DIM_IW-1:0]         p3_row_ff;
   logic [VAL_W-1:0]          p3_prod_ff;
   logic [DIM_IW-1:0]         wr_row_ff;
   logic [VAL_W-1:0]          wr_data_ff;

   // memories and their read registers
   logic [VAL_W-1:0]          vec_mem [MAX_DIM];
   logic [ENT_W-1:0]          ent_mem [MAX_ENTRIES];
   logic [VAL_W-1:0]          sum_mem [MAX_DIM];
   logic [VAL_W-1:0]          vec_rd_ff;
   logic [ENT_W-1:0]          ent_rd_ff;
   logic [VAL_W-1:0]          sum_rd_ff;

   // ---------------------------------------------------------------- combinational
   logic                      cfg_wr;
   logic [0:0]                cfg_idx;
   logic [DIM_CW-1:0]         rows;
   logic [DIM_CW-1:0]         cols;
   logic                      req_acc;
   logic                      vec_wr_en;
   logic [DIM_IW-1:0]         vec_wr_addr;
   logic                      ent_wr_en;
   logic [ENT_W-1:0]          ent_wr_data;
   logic [ENT_AW-1:0]         ent_rd_addr;
   logic [DIM_IW-1:0]         e_row;
   logic [DIM_IW-1:0]         e_col;
   logic [VAL_W-1:0]          e_val;
   logic                      e_row_ok;
   logic [VAL_W-1:0]          prod;
   logic [DIM_IW-1:0]         sum_rd_addr;
   logic [VAL_W-1:0]          acc_base;
   logic [VAL_W-1:0]          acc_sum;
   logic                      emit_last;

   coo_spmv_pkg::div_status_type div_st;
   logic [POS_W-1:0]          div_quo;
   logic [DIM_CW-1:0]         div_rem;

   // apb: register index from the top address bit, writes in the access cycle
   assign pready  = 1'b1;
   assign cfg_idx = paddr[coo_spmv_pkg::ADDR_W-1];
   assign cfg_wr  = psel & penable & pwrite & pready;

   always_comb begin
      case (cfg_idx)
         coo_spmv_pkg::REG_ROW_COUNT: prdata = coo_spmv_pkg::DATA_W'(row_cnt_ff);
         coo_spmv_pkg::REG_COL_COUNT: prdata = coo_spmv_pkg::DATA_W'(col_cnt_ff);
         default:                     prdata = '0;
      endcase
   end

   assign rows = clamp_dim(row_cnt_ff);
   assign cols = clamp_dim(col_cnt_ff);

   // load row and column follow the position; a new column count re-derives them
   coo_spmv_div #(
      .NUM_W (POS_W),
      .DEN_W (DIM_CW)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_pend_ff),
      .num    (pos_ff),
      .den    (cols),
      .status (div_st),
      .quo    (div_quo),
      .rem    (div_rem)
   );

   // words are taken only when idle and the load row/column are current
   assign req_chan.ready = (state_ff == ST_IDLE) && !div_pend_ff && !div_st.busy
                           && !div_st.done;
   assign req_acc        = req_chan.valid & req_chan.ready;

   // entry fields as read from the table
   assign e_row    = ent_rd_ff[ENT_W-1 -: DIM_IW];
   assign e_col    = ent_rd_ff[VAL_W +: DIM_IW];
   assign e_val    = ent_rd_ff[VAL_W-1:0];
   assign e_row_ok = DIM_CW'(e_row) < rows;

   // low word of the product is all the wrapped sum needs
   assign prod = VAL_W'(p2_val_ff * vec_rd_ff);

   // read-modify-write of the row sum; the write of the word just before has
   // not reached the read data yet, so it is forwarded
   always_comb begin
      if (wr_vld_ff && (wr_row_ff == p3_row_ff)) begin
         acc_base = wr_data_ff;
      end else if (row_vld_ff[p3_row_ff]) begin
         acc_base = sum_rd_ff;
      end else begin
         acc_base = '0;
      end
      acc_sum = acc_base + p3_prod_ff;
   end

   assign sum_rd_addr = (state_ff == ST_READ) ? emit_row_ff : p2_row_ff;
   assign emit_last   = (DIM_CW'(emit_row_ff) + DIM_CW'(1)) == rows;

   assign vec_wr_addr = DIM_IW'(req_chan.col_index);
   assign ent_wr_data = {load_row_ff[DIM_IW-1:0], load_col_ff, VAL_W'(req_chan.value)};
   assign ent_rd_addr = walk_idx_ff[ENT_AW-1:0];

   always_comb begin
      state_in    = state_ff;
      row_cnt_in  = row_cnt_ff;
      col_cnt_in  = col_cnt_ff;
      div_pend_in = 1'b0;
      ent_cnt_in  = ent_cnt_ff;
      pos_in      = pos_ff;
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      walk_idx_in = walk_idx_ff;
      p1_vld_in   = 1'b0;
      p2_vld_in   = p1_vld_ff && e_row_ok;
      p3_vld_in   = p2_vld_ff;
      wr_vld_in   = p3_vld_ff;
      row_vld_in  = row_vld_ff;
      emit_row_in = emit_row_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_row_in  = rsp_row_ff;
      rsp_sum_in  = rsp_sum_ff;
      rsp_last_in = rsp_last_ff;
      vec_wr_en   = 1'b0;
      ent_wr_en   = 1'b0;

      if (cfg_wr) begin
         case (cfg_idx)
            coo_spmv_pkg::REG_ROW_COUNT: row_cnt_in = pwdata[CFG_W-1:0];
            coo_spmv_pkg::REG_COL_COUNT: begin
               col_cnt_in  = pwdata[CFG_W-1:0];
               div_pend_in = 1'b1;
            end
            default: ;
         endcase
      end

      if (div_st.done && !div_pend_ff) begin
         load_row_in = div_quo;
         load_col_in = DIM_IW'(div_rem);
      end

      if (p3_vld_ff) begin
         row_vld_in[p3_row_ff] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_chan.mode)
                  coo_spmv_pkg::MODE_VECTOR: begin
                     vec_wr_en = CI_CMP_W'(req_chan.col_index) < CI_CMP_W'(MAX_DIM);
                  end
                  coo_spmv_pkg::MODE_MATRIX: begin
                     // beyond rows*cols once the load row reaches the row count
                     if (load_row_ff < POS_W'(rows)) begin
                        if ((req_chan.value != '0) &&
                            (ent_cnt_ff < ENT_CW'(MAX_ENTRIES))) begin
                           ent_wr_en  = 1'b1;
                           ent_cnt_in = ent_cnt_ff + ENT_CW'(1);
                        end
                        pos_in = pos_ff + POS_W'(1);
                        if ((DIM_CW'(load_col_ff) + DIM_CW'(1)) == cols) begin
                           load_col_in = '0;
                           load_row_in = load_row_ff + POS_W'(1);
                        end else begin
                           load_col_in = load_col_ff + DIM_IW'(1);
                        end
                     end
                  end
                  coo_spmv_pkg::MODE_COMPUTE: begin
                     walk_idx_in = '0;
                     row_vld_in  = '0;
                     state_in    = ST_WALK;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (walk_idx_ff == ent_cnt_ff) begin
               state_in = ST_DRAIN;
            end else begin
               p1_vld_in   = 1'b1;
               walk_idx_in = walk_idx_ff + ENT_CW'(1);
            end
         end
         ST_DRAIN: begin
            if (!p1_vld_ff && !p2_vld_ff && !p3_vld_ff) begin
               emit_row_in = '0;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rsp_vld_in  = 1'b1;
            rsp_row_in  = coo_spmv_pkg::ROW_IDX_W'(emit_row_ff);
            rsp_sum_in  = row_vld_ff[emit_row_ff] ? sum_rd_ff : '0;
            rsp_last_in = emit_last;
            state_in    = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_chan.ready) begin
               rsp_vld_in = 1'b0;
               if (rsp_last_ff) begin
                  // table and load position start over, vector store is kept
                  ent_cnt_in  = '0;
                  pos_in      = '0;
                  load_row_in = '0;
                  load_col_in = '0;
                  state_in    = ST_IDLE;
               end else begin
                  emit_row_in = emit_row_ff + DIM_IW'(1);
                  state_in    = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         row_cnt_ff  <= coo_spmv_pkg::ROW_COUNT_RESET;
         col_cnt_ff  <= coo_spmv_pkg::COL_COUNT_RESET;
         div_pend_ff <= 1'b0;
         ent_cnt_ff  <= '0;
         pos_ff      <= '0;
         load_row_ff <= '0;
         load_col_ff <= '0;
         walk_idx_ff <= '0;
         p1_vld_ff   <= 1'b0;
         p2_vld_ff   <= 1'b0;
         p3_vld_ff   <= 1'b0;
         wr_vld_ff   <= 1'b0;
         row_vld_ff  <= '0;
         emit_row_ff <= '0;
         rsp_vld_ff  <= 1'b0;
         rsp_row_ff  <= '0;
         rsp_sum_ff  <= '0;
         rsp_last_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         row_cnt_ff  <= row_cnt_in;
         col_cnt_ff  <= col_cnt_in;
         div_pend_ff <= div_pend_in;
         ent_cnt_ff  <= ent_cnt_in;
         pos_ff      <= pos_in;
         load_row_ff <= load_row_in;
         load_col_ff <= load_col_in;
         walk_idx_ff <= walk_idx_in;
         p1_vld_ff   <= p1_vld_in;
         p2_vld_ff   <= p2_vld_in;
         p3_vld_ff   <= p3_vld_in;
         wr_vld_ff   <= wr_vld_in;
         row_vld_ff  <= row_vld_in;
         emit_row_ff <= emit_row_in;
         rsp_vld_ff  <= rsp_vld_in;
         rsp_row_ff  <= rsp_row_in;
         rsp_sum_ff  <= rsp_sum_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   // pipeline payload, no reset
   always_ff @(posedge clock) begin
      p2_row_ff  <= e_row;
      p2_val_ff  <= e_val;
      p3_row_ff  <= p2_row_ff;
      p3_prod_ff <= prod;
      wr_row_ff  <= p3_row_ff;
      wr_data_ff <= acc_sum;
   end

   // ---------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      if (vec_wr_en) begin
         vec_mem[vec_wr_addr] <= VAL_W'(req_chan.value);
      end
      vec_rd_ff <= vec_mem[e_col];
   end

   always_ff @(posedge clock) begin
      if (ent_wr_en) begin
         ent_mem[ent_cnt_ff[ENT_AW-1:0]] <= ent_wr_data;
      end
      ent_rd_ff <= ent_mem[ent_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (p3_vld_ff) begin
         sum_mem[p3_row_ff] <= acc_sum;
      end
      sum_rd_ff <= sum_mem[sum_rd_addr];
   end

   // ---------------------------------------------------------------- result word
   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.row_index = rsp_row_ff;
   assign rsp_chan.row_sum   = rsp_sum_ff;
   assign rsp_chan.last_row  = rsp_last_ff;

endmodule
